// ===== rtl/pahf_pkg.sv =====
`timescale 1ns / 1ps

package pahf_pkg;

  // Framing constants of the asynchronous HDLC-like link.
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  // Leading bytes of an LCP frame: address, control, protocol.
  localparam int PATTERN_LEN = 4;
  localparam logic [7:0] LCP_PATTERN [PATTERN_LEN] = '{8'hFF, 8'h03, 8'hC0, 8'h21};

  // Default header hold length and depth of the front to back queue.
  localparam int HEADER_LEN_DEFAULT = 4;
  localparam int FIFO_DEPTH = 4;

  // One request from the front to the back part.
  typedef struct packed {
    logic [7:0]  data;  // raw frame byte
    logic        mode;  // control characters are escaped too
    logic        sof;   // send the opening flag before the byte
    logic        eof;   // send the FCS and the closing flag after the byte
    logic [15:0] fcs;   // complemented FCS, valid with eof
  } entry_t;

  // Output sequencer phases of the back part.
  typedef enum logic [2:0] {
    PH_OPEN,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } phase_e;

  // One byte of the reflected CRC-16 used as the PPP frame check sequence.
  function automatic logic [15:0] fcs_update(logic [15:0] fcs, logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (f[0]) begin
        f = (f >> 1) ^ FCS_POLY;
      end else begin
        f = f >> 1;
      end
    end
    return f;
  endfunction

  // A byte needs an escape pair when it is a flag, an escape, or, in LCP
  // frames, a control character.
  function automatic logic needs_esc(logic [7:0] b, logic mode);
    return (b == FLAG_BYTE) || (b == ESC_BYTE) || (mode && (b < CTRL_LIMIT));
  endfunction

endpackage

// ===== rtl/pahf_fifo.sv =====
`timescale 1ns / 1ps

module pahf_fifo
  import pahf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  entry_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CntW'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the fill count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/pahf_front.sv =====
`timescale 1ns / 1ps

module pahf_front
  import pahf_pkg::*;
#(
  parameter int HeaderLen = HEADER_LEN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       push_o,
  output entry_t     push_data_o,
  input  logic       full_i
);

  localparam int HoldDepth = (HeaderLen > PATTERN_LEN) ? HeaderLen : PATTERN_LEN;
  localparam int IdxW = $clog2(HoldDepth);
  localparam int CntW = $clog2(HeaderLen + 1);

  logic [7:0]      hold_q [HoldDepth];
  logic [CntW-1:0] hcnt_q, hcnt_d;
  logic            mode_q, mode_d;
  logic [15:0]     fcs_q, fcs_d;
  logic            flush_q, flush_d;
  logic [IdxW-1:0] fidx_q, fidx_d;
  logic [IdxW-1:0] flast_q;
  logic            fend_q;
  logic            fmode_q;
  logic [15:0]     ffcs_q;

  logic            accept;
  logic [15:0]     fcs_next;
  logic            in_hold;
  logic            in_header;
  logic            match;
  logic [7:0]      cmp_byte;

  // The input waits while held header bytes drain into the queue or while the queue is full.
  assign in_stall_o = flush_q || full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fcs_next   = fcs_update(fcs_q, data_byte_i);
  assign in_hold    = (hcnt_q < CntW'(HeaderLen - 1)) && !frame_end_i;
  assign in_header  = (hcnt_q < CntW'(HeaderLen));

  // LCP detection over the held bytes and the current one. A frame that
  // ends before the full pattern could be seen is never LCP when the
  // header is long enough to hold the whole pattern.
  always_comb begin
    match    = 1'b1;
    cmp_byte = data_byte_i;
    if ((HeaderLen >= PATTERN_LEN) && (int'(hcnt_q) < PATTERN_LEN - 1)) begin
      match = 1'b0;
    end
    for (int i = 0; i < PATTERN_LEN; i++) begin
      cmp_byte = (i < int'(hcnt_q)) ? hold_q[i] : data_byte_i;
      if ((i <= int'(hcnt_q)) && (cmp_byte != LCP_PATTERN[i])) begin
        match = 1'b0;
      end
    end
  end

  // Requests to the queue: drained header bytes first, then body bytes.
  always_comb begin
    push_o      = 1'b0;
    push_data_o = '{data: data_byte_i, mode: mode_q, sof: 1'b0,
                    eof: frame_end_i, fcs: ~fcs_next};
    if (flush_q) begin
      push_o      = !full_i;
      push_data_o = '{data: hold_q[fidx_q], mode: fmode_q, sof: (fidx_q == '0),
                      eof: fend_q && (fidx_q == flast_q), fcs: ffcs_q};
    end else if (accept && !in_hold && !in_header) begin
      push_o = 1'b1;
    end
  end

  // Frame state: header count, escape mode, running FCS and drain control.
  always_comb begin
    hcnt_d  = hcnt_q;
    mode_d  = mode_q;
    fcs_d   = fcs_q;
    flush_d = flush_q;
    fidx_d  = fidx_q;
    if (accept) begin
      fcs_d = fcs_next;
      if (in_hold) begin
        hcnt_d = hcnt_q + 1'b1;
      end else if (in_header) begin
        flush_d = 1'b1;
        fidx_d  = '0;
        hcnt_d  = CntW'(HeaderLen);
        mode_d  = match;
      end
      if (frame_end_i) begin
        hcnt_d = '0;
        mode_d = 1'b0;
        fcs_d  = FCS_INIT;
      end
    end
    if (flush_q && !full_i) begin
      if (fidx_q == flast_q) begin
        flush_d = 1'b0;
      end else begin
        fidx_d = fidx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q  <= '0;
      mode_q  <= 1'b0;
      fcs_q   <= FCS_INIT;
      flush_q <= 1'b0;
      fidx_q  <= '0;
    end else begin
      hcnt_q  <= hcnt_d;
      mode_q  <= mode_d;
      fcs_q   <= fcs_d;
      flush_q <= flush_d;
      fidx_q  <= fidx_d;
    end
  end

  // Header bytes and the drain descriptor are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (accept && (in_hold || in_header)) begin
      hold_q[IdxW'(hcnt_q)] <= data_byte_i;
    end
    if (accept && !in_hold && in_header) begin
      flast_q <= IdxW'(hcnt_q);
      fend_q  <= frame_end_i;
      fmode_q <= match;
      ffcs_q  <= ~fcs_next;
    end
  end

endmodule

// ===== rtl/pahf_back.sv =====
`timescale 1ns / 1ps

module pahf_back
  import pahf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  output logic       pop_o,
  input  entry_t     pop_data_i,
  input  logic       empty_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  entry_t     cur_q;
  logic       cur_valid_q, cur_valid_d;
  phase_e     phase_q, phase_d;
  logic       esc_q, esc_d;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       ol_q;

  logic       load_ok;
  logic       emit;
  logic       adv;
  logic       done;
  logic [7:0] sel_byte;
  logic [7:0] emit_byte;
  logic       emit_last;

  // The output register takes a new byte when empty or being drained.
  assign load_ok = !ov_q || !out_stall_i;
  assign emit    = cur_valid_q && load_ok;

  // Byte that the current phase sends.
  always_comb begin
    case (phase_q)
      PH_FCS_LO: sel_byte = cur_q.fcs[7:0];
      PH_FCS_HI: sel_byte = cur_q.fcs[15:8];
      default:   sel_byte = cur_q.data;
    endcase
  end

  // Output decode: flag, escape pair halves or plain byte.
  always_comb begin
    emit_byte = sel_byte;
    emit_last = 1'b0;
    adv       = 1'b1;
    esc_d     = 1'b0;
    unique case (phase_q) inside
      PH_OPEN: begin
        emit_byte = FLAG_BYTE;
      end
      PH_DATA, PH_FCS_LO, PH_FCS_HI: begin
        if (esc_q) begin
          emit_byte = sel_byte ^ ESC_XOR;
        end else if (needs_esc(sel_byte, cur_q.mode)) begin
          emit_byte = ESC_BYTE;
          adv       = 1'b0;
          esc_d     = 1'b1;
        end
      end
      PH_CLOSE: begin
        emit_byte = FLAG_BYTE;
        emit_last = 1'b1;
      end
      default: begin
        emit_byte = FLAG_BYTE;
      end
    endcase
  end

  // Next phase; a request is done after its data byte or its closing flag.
  always_comb begin
    phase_d = phase_q;
    done    = 1'b0;
    unique case (phase_q)
      PH_OPEN:   phase_d = PH_DATA;
      PH_DATA: begin
        if (adv && cur_q.eof) begin
          phase_d = PH_FCS_LO;
        end else begin
          done = adv;
        end
      end
      PH_FCS_LO: if (adv) phase_d = PH_FCS_HI;
      PH_FCS_HI: if (adv) phase_d = PH_CLOSE;
      PH_CLOSE:  done = 1'b1;
      default:   done = 1'b1;
    endcase
  end

  // Take the next request in the cycle the current one finishes.
  assign pop_o = !empty_i && (!cur_valid_q || (emit && done));

  always_comb begin
    cur_valid_d = cur_valid_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
    end else if (emit && done) begin
      cur_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= PH_OPEN;
      esc_q       <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      if (pop_o) begin
        phase_q <= pop_data_i.sof ? PH_OPEN : PH_DATA;
        esc_q   <= 1'b0;
      end else if (emit) begin
        phase_q <= phase_d;
        esc_q   <= esc_d;
      end
      if (load_ok) begin
        ov_q <= emit;
      end
    end
  end

  // Current request and output payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_data_i;
    end
    if (emit) begin
      ob_q <= emit_byte;
      ol_q <= emit_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

endmodule

// ===== rtl/ppp_async_hdlc_framer_core.sv =====
`timescale 1ns / 1ps

// PPP asynchronous HDLC-like framer. Raw frame bytes come in with frame_end
// on the last one; framed bytes go out with out_last on the closing flag.
// The first HeaderLen-1 bytes are held until byte HeaderLen (or the frame
// end) arrives, and a frame starting FF 03 C0 21 is framed as LCP with
// control characters escaped; the held bytes then drain into a four-entry
// request queue at one per cycle while it has room, and the input stalls
// meanwhile. After the header a byte is taken every cycle while the queue
// has room. The output sequencer sends one byte per cycle while the output
// is not stalled: a plain byte goes out as itself, an escaped byte as an
// escape pair, and the frame end adds two to four FCS bytes and the closing
// flag. A stalled output byte waits in the output register while the input
// side keeps filling the queue.
module ppp_async_hdlc_framer_core
  import pahf_pkg::*;
#(
  parameter int HeaderLen = HEADER_LEN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic   push;
  entry_t push_data;
  logic   full;
  logic   pop;
  entry_t pop_data;
  logic   empty;

  // Header hold, LCP detection and FCS accumulation.
  pahf_front #(
    .HeaderLen(HeaderLen)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .frame_end_i(frame_end_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  // Request queue between the two halves.
  pahf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  // Flags, escaping and FCS emission.
  pahf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

endmodule

// ===== dv/ppp_async_hdlc_framer_checker.sv =====
`timescale 1ns / 1ps

// Watches both request channels of the framer, predicts the framed byte
// stream from the accepted input bytes and compares it with what the block
// sends, byte by byte.
module ppp_async_hdlc_framer_checker
  import pahf_pkg::*;
#(
  parameter int HeaderLen = HEADER_LEN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         mismatches_o,
  output int         pending_o,
  output int         frames_o,
  output int         lcp_frames_o,
  output int         bytes_out_o
);

  // One framed byte as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } framed_t;

  framed_t     framed_q[$];
  framed_t     oldest;
  logic [7:0]  hdr_held[8];
  int          hdr_taken;
  logic        lcp_mode;
  logic [15:0] fcs_acc;
  int          mismatches = 0;
  int          frames = 0;
  int          lcp_frames = 0;
  int          bytes_out = 0;

  // Reflected CRC-16 step over one byte.
  function automatic logic [15:0] fcs_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ FCS_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic push_framed(input logic [7:0] b, input logic last);
    framed_t item;
    item.data = b;
    item.last = last;
    framed_q.push_back(item);
  endtask

  // Flags and escapes always get an escape pair; control characters only in LCP frames.
  task automatic push_escaped(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE || (lcp_mode && b < CTRL_LIMIT)) begin
      push_framed(ESC_BYTE, 1'b0);
      push_framed(b ^ ESC_XOR, 1'b0);
    end else begin
      push_framed(b, 1'b0);
    end
  endtask

  // Works out the framed bytes that one accepted input request causes.
  task automatic predict_request(input logic [7:0] b, input logic fe);
    int          total;
    int          cmp;
    logic        match;
    logic [7:0]  v;
    logic [15:0] fcs_out;
    fcs_acc = fcs_next(fcs_acc, b);
    if (hdr_taken < HeaderLen - 1 && !fe) begin
      hdr_held[hdr_taken] = b;
      hdr_taken++;
    end else begin
      if (hdr_taken < HeaderLen) begin
        // Header complete or cut short: decide the escape mode and flush.
        total = hdr_taken + 1;
        cmp   = (total < PATTERN_LEN) ? total : PATTERN_LEN;
        match = !(HeaderLen >= PATTERN_LEN && total < PATTERN_LEN);
        for (int i = 0; i < cmp; i++) begin
          v = (i < hdr_taken) ? hdr_held[i] : b;
          if (v != LCP_PATTERN[i]) begin
            match = 1'b0;
          end
        end
        lcp_mode = match;
        if (match) begin
          lcp_frames++;
        end
        push_framed(FLAG_BYTE, 1'b0);
        for (int i = 0; i < hdr_taken; i++) begin
          push_escaped(hdr_held[i]);
        end
        push_escaped(b);
        hdr_taken = HeaderLen;
      end else begin
        push_escaped(b);
      end
      if (fe) begin
        // Complemented FCS low byte first, then the closing flag.
        fcs_out = fcs_acc ^ 16'hFFFF;
        push_escaped(fcs_out[7:0]);
        push_escaped(fcs_out[15:8]);
        push_framed(FLAG_BYTE, 1'b1);
        hdr_taken = 0;
        lcp_mode  = 1'b0;
        fcs_acc   = FCS_INIT;
        frames++;
      end
    end
  endtask

  // Predict on input requests, compare on output requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framed_q.delete();
      hdr_taken = 0;
      lcp_mode  = 1'b0;
      fcs_acc   = FCS_INIT;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_request(data_byte_i, frame_end_i);
      end
      if (out_valid_i && !out_stall_i) begin
        bytes_out++;
        if (framed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: unexpected output byte %02h last %0b", $realtime, out_byte_i,
                     out_last_i);
          end
        end else begin
          oldest = framed_q.pop_front();
          if (oldest.data != out_byte_i || oldest.last != out_last_i) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       $realtime, oldest.data, oldest.last, out_byte_i, out_last_i);
            end
          end
        end
      end
    end
    pending_o    <= framed_q.size();
    mismatches_o <= mismatches;
    frames_o     <= frames;
    lcp_frames_o <= lcp_frames;
    bytes_out_o  <= bytes_out;
  end

endmodule

// ===== dv/ppp_async_hdlc_framer_core_tb.sv =====
`timescale 1ns / 1ps

module ppp_async_hdlc_framer_core_tb;
  import pahf_pkg::*;

  localparam int RandomRequests = 75;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int         mismatches;
  int         pending;
  int         frames;
  int         lcp_frames;
  int         bytes_out;
  int         requests_sent = 0;
  logic       tx_calm = 1'b0;
  logic [7:0] frame_buf[$];

  always #5 clk = ~clk;

  ppp_async_hdlc_framer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .frame_end_i (frame_end),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  ppp_async_hdlc_framer_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_byte_i  (data_byte),
    .frame_end_i  (frame_end),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .out_last_i   (out_last),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .frames_o     (frames),
    .lcp_frames_o (lcp_frames),
    .bytes_out_o  (bytes_out)
  );

  // Sends one input request after a random gap (none in a calm frame) and waits until it is taken.
  task automatic send_request(input logic [7:0] b, input logic fe);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Sends the bytes in frame_buf as one frame, frame_end on the last byte.
  task automatic send_frame();
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_request(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Holds the input off until every predicted byte has come out.
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Payload bytes lean toward the ones that need escaping.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Output side: a random stall before each request, with calm stretches.
  initial begin
    int   wait_cycles;
    int   served;
    logic rx_calm;
    served  = 0;
    rx_calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (served % 24 == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      wait_cycles = rx_calm ? 0 : $urandom_range(0, 12);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  // Input side: directed frames, then random frames, then the verdict.
  initial begin
    int directed;
    int len;
    int kind;
    int idx;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // LCP frame with control characters, a flag, an escape and the byte extremes.
    frame_buf = '{8'hFF, 8'h03, 8'hC0, 8'h21, 8'h00, 8'h1F, 8'h7E, 8'h7D, 8'h20, 8'hFF};
    send_frame();
    // Near miss of the LCP header: only flags and escapes are escaped.
    frame_buf = '{8'hFF, 8'h03, 8'hC1, 8'h21, 8'h00, 8'h7D};
    send_frame();
    // Frames shorter than the header, one of them the LCP prefix.
    frame_buf = '{8'h7E};
    send_frame();
    frame_buf = '{8'h00, 8'hFF};
    send_frame();
    frame_buf = '{8'hFF, 8'h03, 8'hC0};
    send_frame();
    // Frame that is exactly the LCP header.
    frame_buf = '{8'hFF, 8'h03, 8'hC0, 8'h21};
    send_frame();
    directed = requests_sent;
    drain_pause();

    // Random frames: mostly LCP headers or near misses, random content.
    while (requests_sent < directed + RandomRequests) begin
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      kind = $urandom_range(0, 9);
      frame_buf.delete();
      for (int i = 0; i < len; i++) begin
        if (i < PATTERN_LEN && kind < 6) begin
          frame_buf.push_back(LCP_PATTERN[i]);
        end else begin
          frame_buf.push_back(payload_byte());
        end
      end
      if (kind >= 4 && kind < 6) begin
        idx = $urandom_range(0, ((len < PATTERN_LEN) ? len : PATTERN_LEN) - 1);
        frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      send_frame();
      if ($urandom_range(0, 5) == 0) begin
        drain_pause();
      end
    end

    // Let the last frame drain completely.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input bytes in %0d frames, %0d of them framed as LCP.",
             requests_sent, frames, lcp_frames);
    $display("Checked %0d framed output bytes, %0d mismatches.", bytes_out, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[ppp_async_hdlc_framer_core] OK");
    end else begin
      $display("[ppp_async_hdlc_framer_core] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("[ppp_async_hdlc_framer_core] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pahf_pkg.sv
rtl/pahf_fifo.sv
rtl/pahf_front.sv
rtl/pahf_back.sv
rtl/ppp_async_hdlc_framer_core.sv
dv/ppp_async_hdlc_framer_checker.sv
dv/ppp_async_hdlc_framer_core_tb.sv
